// File: sv/wsdf_pkg.sv
// Shared types and constants for the WebSocket frame deframer.
// No dependencies; imported by every module of the block.
package wsdf_pkg;

    localparam int LEN_BITS = 64;

    localparam logic [3:0] OPC_CLOSE = 4'h8;
    localparam logic [6:0] LEN_EXT16 = 7'd126;
    localparam logic [6:0] LEN_EXT64 = 7'd127;

    // Index of the last extended-length byte in each form, and of the last masking-key byte
    localparam logic [2:0] EXT16_LAST = 3'd1;
    localparam logic [2:0] EXT64_LAST = 3'd7;
    localparam logic [2:0] KEY_LAST   = 3'd3;

    typedef logic [1:0] t_kind;
    localparam t_kind KIND_DATA  = 2'd0;
    localparam t_kind KIND_EMPTY = 2'd1;
    localparam t_kind KIND_CLOSE = 2'd2;

    typedef enum logic [4:0] {
        PH_HDR0    = 5'b00001,
        PH_HDR1    = 5'b00010,
        PH_EXTLEN  = 5'b00100,
        PH_MASKKEY = 5'b01000,
        PH_PAYLOAD = 5'b10000
    } t_phase;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] data;
        logic       eom;
    } t_result;

endpackage

// File: sv/wsdf_parser.sv
// Frame header parser and payload unmasking for the WebSocket deframer.
// Depends on wsdf_pkg.
module wsdf_parser (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [7:0]        i_byte,
    output logic              o_emit,
    output wsdf_pkg::t_result o_result
);
    import wsdf_pkg::*;

    t_phase              r_phase, n_phase;
    logic [2:0]          r_cnt, n_cnt;
    logic                r_ext_long, n_ext_long;
    logic [LEN_BITS-1:0] r_rem, n_rem;
    logic [31:0]         r_key, n_key;
    logic [1:0]          r_mpos, n_mpos;
    logic                r_mask, n_mask;
    logic                r_close, n_close;

    logic       hdr_end;
    logic       emit;
    t_result    res;
    logic [7:0] key_byte;
    logic [2:0] ext_last;

    always_comb begin
        case (r_mpos)
            2'd0:    key_byte = r_key[31:24];
            2'd1:    key_byte = r_key[23:16];
            2'd2:    key_byte = r_key[15:8];
            default: key_byte = r_key[7:0];
        endcase
        if (!r_mask) begin
            key_byte = 8'h00;
        end
    end

    assign ext_last = r_ext_long ? EXT64_LAST : EXT16_LAST;

    always_comb begin
        n_phase    = r_phase;
        n_cnt      = r_cnt;
        n_ext_long = r_ext_long;
        n_rem      = r_rem;
        n_key      = r_key;
        n_mpos     = r_mpos;
        n_mask     = r_mask;
        n_close    = r_close;
        hdr_end    = 1'b0;
        emit       = 1'b0;
        res        = '0;

        unique case (r_phase)
            PH_HDR1: begin
                n_mask = i_byte[7];
                n_key  = '0;
                n_cnt  = '0;
                if (i_byte[6:0] == LEN_EXT16) begin
                    n_ext_long = 1'b0;
                    n_rem      = '0;
                    n_phase    = PH_EXTLEN;
                end else if (i_byte[6:0] == LEN_EXT64) begin
                    n_ext_long = 1'b1;
                    n_rem      = '0;
                    n_phase    = PH_EXTLEN;
                end else begin
                    n_ext_long = 1'b0;
                    n_rem      = LEN_BITS'(i_byte[6:0]);
                    if (i_byte[7]) begin
                        n_phase = PH_MASKKEY;
                    end else begin
                        hdr_end = 1'b1;
                    end
                end
            end
            PH_EXTLEN: begin
                // shift in big-endian, high bits fall off the top
                n_rem = {r_rem[LEN_BITS-9:0], i_byte};
                if (r_cnt == ext_last) begin
                    n_cnt = '0;
                    if (r_mask) begin
                        n_phase = PH_MASKKEY;
                    end else begin
                        hdr_end = 1'b1;
                    end
                end else begin
                    n_cnt = r_cnt + 3'd1;
                end
            end
            PH_MASKKEY: begin
                n_key = {r_key[23:0], i_byte};
                if (r_cnt >= KEY_LAST) begin
                    hdr_end = 1'b1;
                end else begin
                    n_cnt = r_cnt + 3'd1;
                end
            end
            PH_PAYLOAD: begin
                n_mpos = r_mpos + 2'd1;
                n_rem  = r_rem - LEN_BITS'(1);
                if (n_rem == '0) begin
                    n_phase = PH_HDR0;
                end
                if (r_close) begin
                    // drop close payload, report once at the frame end
                    if (n_rem == '0) begin
                        emit     = 1'b1;
                        res.kind = KIND_CLOSE;
                        res.eom  = 1'b1;
                    end
                end else begin
                    emit     = 1'b1;
                    res.kind = KIND_DATA;
                    res.data = i_byte ^ key_byte;
                    res.eom  = (n_rem == '0);
                end
            end
            default: begin
                n_close = (i_byte[3:0] == OPC_CLOSE);
                n_phase = PH_HDR1;
            end
        endcase

        if (hdr_end) begin
            n_cnt  = '0;
            n_mpos = '0;
            if (n_rem == '0) begin
                n_phase  = PH_HDR0;
                emit     = 1'b1;
                res.kind = r_close ? KIND_CLOSE : KIND_EMPTY;
                res.data = 8'h00;
                res.eom  = 1'b1;
            end else begin
                n_phase = PH_PAYLOAD;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_HDR0;
            r_cnt      <= '0;
            r_ext_long <= 1'b0;
            r_rem      <= '0;
            r_key      <= '0;
            r_mpos     <= '0;
            r_mask     <= 1'b0;
            r_close    <= 1'b0;
        end else if (i_accept) begin
            r_phase    <= n_phase;
            r_cnt      <= n_cnt;
            r_ext_long <= n_ext_long;
            r_rem      <= n_rem;
            r_key      <= n_key;
            r_mpos     <= n_mpos;
            r_mask     <= n_mask;
            r_close    <= n_close;
        end
    end

    assign o_emit   = i_accept & emit;
    assign o_result = res;

endmodule

// File: sv/wsdf_out_buf.sv
// Result register with one skid entry for the WebSocket deframer output.
// Depends on wsdf_pkg.
module wsdf_out_buf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  wsdf_pkg::t_result i_result,
    output logic              o_space,
    output logic              o_valid,
    input  logic              i_ready,
    output wsdf_pkg::t_result o_result
);
    import wsdf_pkg::*;

    logic    r_main_valid;
    t_result r_main;
    logic    r_skid_valid;
    t_result r_skid;
    logic    pop;

    assign pop     = r_main_valid & i_ready;
    assign o_space = ~r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (!r_main_valid || pop) begin
                // refill from skid first to keep order
                if (r_skid_valid) begin
                    r_main_valid <= 1'b1;
                    r_skid_valid <= 1'b0;
                end else begin
                    r_main_valid <= i_push;
                end
            end else if (i_push) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_main_valid || pop) begin
            r_main <= r_skid_valid ? r_skid : i_result;
        end
        if (r_main_valid && !pop && i_push) begin
            r_skid <= i_result;
        end
    end

    assign o_valid  = r_main_valid;
    assign o_result = r_main;

endmodule

// File: sv/websocket_frame_deframer.sv
// Top level of the WebSocket frame deframer: header parser plus output buffer.
// Depends on wsdf_pkg, wsdf_parser and wsdf_out_buf.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries the received stream one
//   byte per transaction. Output channel (o_out_valid / i_out_ready) carries
//   results: a payload byte (unmasked), an empty-message marker for a
//   zero-length frame, or a close marker at the end of a close frame.
//   o_end_of_message flags the last result of each frame.
//   Header and masking-key bytes produce no result, save that the last
//   header byte of a zero-length frame produces its marker. Each result is
//   registered in the output register, or in the skid entry while that is
//   held. Throughput: one byte per cycle while the skid entry is free.
//   Reset (synchronous, active low) returns the parser to expect the first
//   header byte of a frame and empties the output buffer.
//   When the receiver stalls, one more result is held in a skid entry; the
//   input stalls only once both output entries are full.
module websocket_frame_deframer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_stream_byte,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [1:0] o_result_kind,
    output logic [7:0] o_data_byte,
    output logic       o_end_of_message
);
    import wsdf_pkg::*;

    logic    accept;
    logic    emit;
    logic    space;
    t_result parse_res;
    t_result out_res;

    assign o_in_ready = space;
    assign accept     = i_in_valid & space;

    wsdf_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_byte   (i_stream_byte),
        .o_emit   (emit),
        .o_result (parse_res)
    );

    wsdf_out_buf u_out_buf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (emit),
        .i_result (parse_res),
        .o_space  (space),
        .o_valid  (o_out_valid),
        .i_ready  (i_out_ready),
        .o_result (out_res)
    );

    assign o_result_kind    = out_res.kind;
    assign o_data_byte      = out_res.data;
    assign o_end_of_message = out_res.eom;

endmodule

// File: bench/wsdf_frame_checker.sv
// Frame checker for the WebSocket frame deframer: decodes every accepted stream
// byte into the results it should produce and matches them against the output.
// Depends on wsdf_pkg for the phase, kind, result and length codes.
module wsdf_frame_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  logic [7:0] i_stream_byte,
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  logic [1:0] i_result_kind,
    input  logic [7:0] i_data_byte,
    input  logic       i_end_of_message,
    output int         o_fail_count,
    output int         o_pending
);
    import wsdf_pkg::*;

    typedef enum logic [1:0] {
        FORM_SHORT = 2'd0,
        FORM_EXT16 = 2'd1,
        FORM_EXT64 = 2'd2
    } t_len_form;

    // Decoder state, a mirror of the block's parser
    t_phase              frm_phase;
    logic [2:0]          hdr_cnt;
    t_len_form           len_form;
    logic [LEN_BITS-1:0] bytes_left;
    logic [31:0]         mask_key;
    logic [1:0]          key_idx;
    logic                masked;
    logic                closing;

    t_result decoded_q[$];
    t_result want;
    logic    bad;

    // End of header: a zero length closes the frame at once
    task automatic finish_header(output logic emit_res, output t_result r);
        hdr_cnt  = '0;
        key_idx  = '0;
        emit_res = 1'b0;
        r        = '0;
        if (bytes_left == '0) begin
            frm_phase = PH_HDR0;
            emit_res  = 1'b1;
            r.kind    = closing ? KIND_CLOSE : KIND_EMPTY;
            r.eom     = 1'b1;
        end else begin
            frm_phase = PH_PAYLOAD;
        end
    endtask

    task automatic decode_byte(input logic [7:0] b);
        t_result    r;
        logic       emit_res;
        logic [7:0] kb;
        logic [2:0] last_idx;
        r        = '0;
        emit_res = 1'b0;
        case (frm_phase)
            PH_HDR1: begin
                masked   = b[7];
                mask_key = '0;
                hdr_cnt  = '0;
                if (b[6:0] == LEN_EXT16 || b[6:0] == LEN_EXT64) begin
                    len_form   = (b[6:0] == LEN_EXT16) ? FORM_EXT16 : FORM_EXT64;
                    bytes_left = '0;
                    frm_phase  = PH_EXTLEN;
                end else begin
                    len_form   = FORM_SHORT;
                    bytes_left = LEN_BITS'(b[6:0]);
                    if (masked) frm_phase = PH_MASKKEY;
                    else finish_header(emit_res, r);
                end
            end
            PH_EXTLEN: begin
                last_idx   = (len_form == FORM_EXT16) ? EXT16_LAST : EXT64_LAST;
                bytes_left = (bytes_left << 8) | LEN_BITS'(b);
                if (hdr_cnt >= last_idx) begin
                    hdr_cnt = '0;
                    if (masked) frm_phase = PH_MASKKEY;
                    else finish_header(emit_res, r);
                end else begin
                    hdr_cnt = hdr_cnt + 3'd1;
                end
            end
            PH_MASKKEY: begin
                mask_key = {mask_key[23:0], b};
                if (hdr_cnt >= KEY_LAST) finish_header(emit_res, r);
                else hdr_cnt = hdr_cnt + 3'd1;
            end
            PH_PAYLOAD: begin
                // First key byte received sits in the top of the key register
                kb         = masked ? 8'(mask_key >> (8 * (3 - int'(key_idx)))) : 8'h00;
                key_idx    = key_idx + 2'd1;
                bytes_left = bytes_left - 1'b1;
                if (bytes_left == '0) frm_phase = PH_HDR0;
                if (closing) begin
                    if (bytes_left == '0) begin
                        emit_res = 1'b1;
                        r.kind   = KIND_CLOSE;
                        r.eom    = 1'b1;
                    end
                end else begin
                    emit_res = 1'b1;
                    r.kind   = KIND_DATA;
                    r.data   = b ^ kb;
                    r.eom    = (bytes_left == '0);
                end
            end
            default: begin
                closing   = (b[3:0] == OPC_CLOSE);
                frm_phase = PH_HDR1;
            end
        endcase
        if (emit_res) decoded_q.push_back(r);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            frm_phase    = PH_HDR0;
            hdr_cnt      = '0;
            len_form     = FORM_SHORT;
            bytes_left   = '0;
            mask_key     = '0;
            key_idx      = '0;
            masked       = 1'b0;
            closing      = 1'b0;
            o_fail_count = 0;
            decoded_q.delete();
        end else begin
            // Check the output transaction first: its expectation is from an earlier byte
            if (i_out_valid === 1'b1 && i_out_ready === 1'b1) begin
                if (decoded_q.size() == 0) begin
                    $display("%0t: unexpected result: expected none, got kind %0d data %02h eom %0b",
                             $time, i_result_kind, i_data_byte, i_end_of_message);
                    o_fail_count = o_fail_count + 1;
                end else begin
                    want = decoded_q.pop_front();
                    bad  = 1'b0;
                    if (i_result_kind !== want.kind) begin
                        $display("%0t: result_kind mismatch: expected %0d, got %0d",
                                 $time, want.kind, i_result_kind);
                        bad = 1'b1;
                    end
                    if (i_data_byte !== want.data) begin
                        $display("%0t: data_byte mismatch: expected %02h, got %02h",
                                 $time, want.data, i_data_byte);
                        bad = 1'b1;
                    end
                    if (i_end_of_message !== want.eom) begin
                        $display("%0t: end_of_message mismatch: expected %0b, got %0b",
                                 $time, want.eom, i_end_of_message);
                        bad = 1'b1;
                    end
                    if (bad) o_fail_count = o_fail_count + 1;
                end
            end
            if (i_in_valid === 1'b1 && i_in_ready === 1'b1) decode_byte(i_stream_byte);
        end
        o_pending = decoded_q.size();
    end

endmodule

// File: bench/tb_websocket_frame_deframer.sv
// Testbench top for the WebSocket frame deframer: builds a framed byte stream,
// drives it with random stalls on both channels and gives the verdict.
// Depends on wsdf_pkg, websocket_frame_deframer and wsdf_frame_checker.
module tb_websocket_frame_deframer;
    import wsdf_pkg::*;

    localparam logic [3:0] OPC_TEXT     = 4'h1;
    localparam logic [3:0] OPC_BINARY   = 4'h2;
    localparam logic [3:0] OPC_RESERVED = 4'hB;

    localparam int STREAM_TARGET = 916;
    localparam int DRAIN_ITEMS   = 150;

    logic       clk            = 1'b0;
    logic       rst_n          = 1'b0;
    logic       in_valid       = 1'b0;
    logic       in_ready;
    logic [7:0] stream_byte    = 8'h00;
    logic       out_valid;
    logic       out_ready      = 1'b0;
    logic [1:0] result_kind;
    logic [7:0] data_byte;
    logic       end_of_message;

    int   fails;
    int   pending;
    bit   drain = 1'b0;

    logic [7:0] stream_q[$];

    websocket_frame_deframer dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .o_in_ready      (in_ready),
        .i_stream_byte   (stream_byte),
        .o_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .o_result_kind   (result_kind),
        .o_data_byte     (data_byte),
        .o_end_of_message(end_of_message)
    );

    wsdf_frame_checker u_check (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .i_in_ready      (in_ready),
        .i_stream_byte   (stream_byte),
        .i_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .i_result_kind   (result_kind),
        .i_data_byte     (data_byte),
        .i_end_of_message(end_of_message),
        .o_fail_count    (fails),
        .o_pending       (pending)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    initial begin
        #1_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // Append one frame; len_code is the 7-bit length field, len the extended value
    task automatic add_frame(input logic [7:0] first, input logic masked,
                             input logic [6:0] len_code, input logic [63:0] len,
                             input int npay);
        stream_q.push_back(first);
        stream_q.push_back({masked, len_code});
        if (len_code == LEN_EXT16) begin
            for (int i = 1; i >= 0; i--) stream_q.push_back(len[8*i +: 8]);
        end else if (len_code == LEN_EXT64) begin
            for (int i = 7; i >= 0; i--) stream_q.push_back(len[8*i +: 8]);
        end
        if (masked) repeat (4) stream_q.push_back(8'($urandom_range(0, 255)));
        repeat (npay) stream_q.push_back(8'($urandom_range(0, 255)));
    endtask

    task automatic add_random_frame();
        logic [3:0]  opc;
        logic [6:0]  code;
        logic [63:0] len;
        int          sel;
        opc = 4'($urandom_range(0, 15));
        if ($urandom_range(0, 5) == 0) opc = OPC_CLOSE;
        sel = $urandom_range(0, 99);
        if (sel < 65) begin
            len  = (sel < 60) ? 64'($urandom_range(0, 15)) : 64'($urandom_range(100, 125));
            code = len[6:0];
        end else if (sel < 82) begin
            len  = ($urandom_range(0, 9) == 0) ? 64'($urandom_range(256, 270))
                                               : 64'($urandom_range(0, 30));
            code = LEN_EXT16;
        end else begin
            len  = 64'($urandom_range(0, 30));
            code = LEN_EXT64;
        end
        add_frame({4'($urandom_range(0, 15)), opc}, 1'($urandom_range(0, 1)),
                  code, len, int'(len));
    endtask

    // Receiver: random stall bursts until the drain phase
    initial begin
        @(posedge clk);
        forever begin
            if (!drain && $urandom_range(0, 2) == 0) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge clk);
            end
            out_ready <= 1'b1;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    end

    initial begin
        // Empty text frame, empty close frame
        add_frame({4'h8, OPC_TEXT}, 1'b0, 7'd0, 64'd0, 0);
        add_frame({4'h8, OPC_CLOSE}, 1'b0, 7'd0, 64'd0, 0);
        // All flag bits set, masked, payload byte extremes
        add_frame({4'hF, OPC_BINARY}, 1'b1, 7'd2, 64'd2, 0);
        stream_q.push_back(8'h00);
        stream_q.push_back(8'hFF);
        // Masked close frame with a 16-bit length carrying payload to discard
        add_frame({4'h0, OPC_CLOSE}, 1'b1, LEN_EXT16, 64'd1, 1);
        // Reserved opcode with a zero extended length
        add_frame({4'h7, OPC_RESERVED}, 1'b0, LEN_EXT16, 64'd0, 0);
        while (stream_q.size() < STREAM_TARGET) add_random_frame();
        // Maximal 64-bit length: the frame never ends, so the run stops inside it
        add_frame({4'h8, OPC_BINARY}, 1'b1, LEN_EXT64, '1, 20);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        foreach (stream_q[i]) begin
            if (i >= stream_q.size() - DRAIN_ITEMS) drain = 1'b1;
            if (!drain && $urandom_range(0, 4) == 0) begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge clk);
            end
            in_valid    <= 1'b1;
            stream_byte <= stream_q[i];
            // Hold until the transaction goes through
            do @(posedge clk); while (in_ready !== 1'b1);
        end
        in_valid <= 1'b0;

        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        if (fails == 0 && pending == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
